// ----- src/lkc_pkg.sv -----
// shared types and constants for the lru key cache
package lkc_pkg;

	localparam int LKC_ENTRIES  = 16;
	localparam int LKC_KEY_BITS = 16;
	localparam int FIELD_KEY_W  = 16;
	localparam int CAP_W        = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		CLS_NOP,
		CLS_LOOKUP,
		CLS_INSERT
	} item_class_t;

	typedef enum logic {
		KIND_LOOKUP = 1'b0,
		KIND_INSERT = 1'b1
	} kind_t;

	typedef struct packed {
		item_class_t             cls;
		logic [FIELD_KEY_W-1:0] key;
	} q_item_t;

endpackage

// ----- src/lkc_front.sv -----
// front end: takes command beats, classifies them and queues them for the store
module lkc_front import lkc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   kind,
	input  logic [FIELD_KEY_W-1:0] key,
	input  logic                   cap_zero,
	input  logic                   pop,
	output logic                   busy,
	output logic                   head_valid,
	output q_item_t                head
);

	q_item_t             fifo_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                push;
	logic                do_pop;
	q_item_t             item;

	assign busy       = (count_q == QCNT_W'(QDEPTH));
	assign push       = start && !busy;
	assign head_valid = (count_q != '0);
	assign do_pop     = pop && head_valid;
	assign head       = fifo_q[rd_ptr_q];

	// disabled cache turns everything into a no-op
	always_comb begin
		item.key = key;
		if (cap_zero) begin
			item.cls = CLS_NOP;
		end else if (kind_t'(kind) == KIND_INSERT) begin
			item.cls = CLS_INSERT;
		end else begin
			item.cls = CLS_LOOKUP;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- src/lkc_store.sv -----
// back end: associative key store with lru ages and the result register
module lkc_store import lkc_pkg::*; #(
	parameter int ENTRIES  = LKC_ENTRIES,
	parameter int KEY_BITS = LKC_KEY_BITS,
	localparam int AW = $clog2(ENTRIES),
	localparam int OW = $clog2(ENTRIES + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   clr,
	input  logic [OW-1:0]          cap_eff,
	input  logic                   head_valid,
	input  q_item_t                head,
	output logic                   pop,
	output logic                   done,
	output logic                   hit,
	output logic                   evicted_valid,
	output logic [FIELD_KEY_W-1:0] evicted_key
);

	logic [KEY_BITS-1:0] key_q [ENTRIES];
	logic [AW-1:0]       age_q [ENTRIES];
	logic [AW-1:0]       age_d [ENTRIES];
	logic [ENTRIES-1:0]  valid_q;
	logic [ENTRIES-1:0]  valid_d;
	logic [OW-1:0]       occ_q;
	logic [OW-1:0]       occ_d;

	logic [KEY_BITS-1:0] k;
	logic [ENTRIES-1:0]  match;
	logic [ENTRIES-1:0]  oldest;
	logic [ENTRIES-1:0]  free;
	logic [ENTRIES-1:0]  wr_slot;
	logic                any_hit;
	logic                full;
	logic [AW-1:0]       hit_age;
	logic [AW-1:0]       old_age;
	logic [KEY_BITS-1:0] old_key;
	logic                res_hit;
	logic                res_ev;
	logic [KEY_BITS-1:0] res_evkey;
	logic                done_q;
	logic                hit_q;
	logic                ev_valid_q;
	logic [FIELD_KEY_W-1:0] ev_key_q;

	assign pop     = head_valid;
	assign k       = KEY_BITS'(head.key);
	assign any_hit = |match;
	assign full    = (occ_q >= cap_eff);
	assign old_age = AW'(occ_q - 1'b1);
	// lowest empty slot
	assign free    = ~valid_q & (valid_q + 1'b1);

	// ages of valid entries are a permutation of 0..occ-1, so lru is age occ-1
	always_comb begin
		hit_age = '0;
		old_key = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i]  = valid_q[i] && (key_q[i] == k);
			oldest[i] = valid_q[i] && (age_q[i] == old_age);
			hit_age   = hit_age | (match[i] ? age_q[i] : '0);
			old_key   = old_key | (oldest[i] ? key_q[i] : '0);
		end
	end

	always_comb begin
		valid_d   = valid_q;
		age_d     = age_q;
		occ_d     = occ_q;
		wr_slot   = '0;
		res_hit   = 1'b0;
		res_ev    = 1'b0;
		res_evkey = '0;
		if (head_valid && head.cls != CLS_NOP) begin
			if (any_hit) begin
				res_hit = 1'b1;
				for (int i = 0; i < ENTRIES; i++) begin
					if (match[i]) begin
						age_d[i] = '0;
					end else if (valid_q[i] && age_q[i] < hit_age) begin
						age_d[i] = age_q[i] + 1'b1;
					end
				end
			end else if (head.cls == CLS_INSERT) begin
				if (full) begin
					res_ev    = 1'b1;
					res_evkey = old_key;
					wr_slot   = oldest;
				end else begin
					wr_slot = free;
					occ_d   = occ_q + 1'b1;
				end
				for (int i = 0; i < ENTRIES; i++) begin
					if (wr_slot[i]) begin
						age_d[i]   = '0;
						valid_d[i] = 1'b1;
					end else if (valid_q[i]) begin
						age_d[i] = age_q[i] + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (wr_slot[i]) begin
				key_q[i] <= k;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			occ_q      <= '0;
			done_q     <= 1'b0;
			hit_q      <= 1'b0;
			ev_valid_q <= 1'b0;
			ev_key_q   <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else if (clr) begin
			valid_q <= '0;
			occ_q   <= '0;
			done_q  <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else begin
			valid_q    <= valid_d;
			occ_q      <= occ_d;
			age_q      <= age_d;
			done_q     <= head_valid;
			hit_q      <= res_hit;
			ev_valid_q <= res_ev;
			ev_key_q   <= FIELD_KEY_W'(res_evkey);
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_key   = ev_key_q;

`ifndef ASSERT_OFF
	a_unique_keys: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("key stored in more than one valid entry");

	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == OW'($countones(valid_q)))
		else $error("occupancy disagrees with valid entries");

	a_occ_cap: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= cap_eff)
		else $error("occupancy above capacity");

	a_done_follows_pop: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(pop))
		else $error("result strobe without a queued item");

	a_evict_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid_q |-> (!hit_q && done_q))
		else $error("eviction reported on a hit or without a result");
`endif

endmodule

// ----- src/lru_key_cache.sv -----
// top level of the lru key cache: capacity register, front queue and key store
//
// usage:
//  - command channel: a beat is taken at a rising edge with start high and busy
//    low; kind selects lookup or insert, key is the key to look up or insert
//  - result channel: done is high for exactly one cycle per command beat, with
//    hit, evicted_valid and evicted_key valid in that cycle; results come back
//    in command order and the receiver has no way to hold them off
//  - capacity: written by cfg_we/cfg_wdata while the cache is idle; every write
//    empties the store, zero disables it, values above ENTRIES act as ENTRIES
//  - result timing: the accepting edge writes the beat into the queue, and the
//    strobe and its fields come from the result register loaded from that entry
//  - throughput: one command per cycle; the store does its compare across all
//    entries and its age update combinationally and pops the queue head whenever
//    it is valid, so the two-deep queue never holds more than one beat and busy
//    stays low
//  - reset: store empty, capacity 16, queue empty, no strobe
module lru_key_cache import lkc_pkg::*; #(
	parameter int ENTRIES  = LKC_ENTRIES,
	parameter int KEY_BITS = LKC_KEY_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   kind,
	input  logic [FIELD_KEY_W-1:0] key,
	input  logic                   cfg_we,
	input  logic [CAP_W-1:0]       cfg_wdata,
	output logic                   done,
	output logic                   hit,
	output logic                   evicted_valid,
	output logic [FIELD_KEY_W-1:0] evicted_key
);

	localparam int OW = $clog2(ENTRIES + 1);
	// wide enough for both the capacity field and the entry count
	localparam int CW = (OW > CAP_W) ? OW : CAP_W;

	logic [CAP_W-1:0] capacity_q;
	logic [OW-1:0]    cap_eff;
	logic             cap_zero;
	logic             pop;
	logic             head_valid;
	q_item_t          head;

	// capacity register, a write also clears the store below
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// saturate capacity at the number of physical entries
	assign cap_eff  = (CW'(capacity_q) > CW'(ENTRIES)) ? OW'(ENTRIES) : OW'(capacity_q);
	assign cap_zero = (capacity_q == '0);

	// front: command beat in, classified, queued
	lkc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.kind       (kind),
		.key        (key),
		.cap_zero   (cap_zero),
		.pop        (pop),
		.busy       (busy),
		.head_valid (head_valid),
		.head       (head)
	);

	// back: one queued item per cycle against the key store
	lkc_store #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS)
	) u_store (
		.clk           (clk),
		.arst_n        (arst_n),
		.clr           (cfg_we),
		.cap_eff       (cap_eff),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.done          (done),
		.hit           (hit),
		.evicted_valid (evicted_valid),
		.evicted_key   (evicted_key)
	);

endmodule

// ----- verif/tb_lru_key_cache.sv -----
// self-checking testbench for the lru key cache: directed and random beats against a shadow lru model
module tb_lru_key_cache;
	import lkc_pkg::*;

	// the strobe trails the accepting edge by the queue and the result register, which the drain covers
	localparam int DRAIN_CYCLES = 6;
	// slowest run is roughly 1500 beats plus their random idle gaps and the drains
	localparam int CYCLE_LIMIT  = 200000;

	// one expected result beat
	typedef struct packed {
		logic                   hit;
		logic                   evicted_valid;
		logic [FIELD_KEY_W-1:0] evicted_key;
	} lru_outcome_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   start         = 1'b0;
	logic                   busy;
	logic                   kind          = 1'b0;
	logic [FIELD_KEY_W-1:0] key           = '0;
	logic                   cfg_we        = 1'b0;
	logic [CAP_W-1:0]       cfg_wdata     = '0;
	logic                   done;
	logic                   hit;
	logic                   evicted_valid;
	logic [FIELD_KEY_W-1:0] evicted_key;

	// shadow copy of the store, kept in the same slot order as the block
	logic [FIELD_KEY_W-1:0] shadow_key   [LKC_ENTRIES];
	bit                     shadow_valid [LKC_ENTRIES];
	int unsigned            shadow_age   [LKC_ENTRIES];
	int unsigned            shadow_fill;
	logic [CAP_W-1:0]       shadow_cap;

	// expected result beats, oldest first
	lru_outcome_t pending_results[$];

	int unsigned mismatches  = 0;
	int unsigned cycle_count = 0;
	bit          idle_on     = 1'b1;

	lru_key_cache DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.key           (key),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.done          (done),
		.hit           (hit),
		.evicted_valid (evicted_valid),
		.evicted_key   (evicted_key)
	);

	always #1 clk = ~clk;

	// watchdog: a hang or a lost result ends here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// empty the shadow store, as a capacity write does
	function automatic void shadow_clear();
		for (int i = 0; i < LKC_ENTRIES; i++) begin
			shadow_key[i]   = '0;
			shadow_valid[i] = 1'b0;
			shadow_age[i]   = 0;
		end
		shadow_fill = 0;
	endfunction

	// one lookup or insert on the shadow store; returns the result beat it causes
	function automatic lru_outcome_t lru_access(kind_t op, logic [FIELD_KEY_W-1:0] k);
		lru_outcome_t res;
		int           eff_cap;
		int           slot;
		int           oldest;
		int unsigned  hit_age;
		res     = '0;
		slot    = -1;
		// capacities above the entry count saturate
		eff_cap = (shadow_cap > LKC_ENTRIES) ? LKC_ENTRIES : int'(shadow_cap);
		if (eff_cap != 0) begin
			for (int i = 0; i < LKC_ENTRIES; i++)
				if (slot < 0 && shadow_valid[i] && shadow_key[i] == k)
					slot = i;
			if (slot >= 0) begin
				// hit: entries younger than this one age by one, this one becomes newest
				res.hit = 1'b1;
				hit_age = shadow_age[slot];
				for (int i = 0; i < LKC_ENTRIES; i++)
					if (shadow_valid[i] && i != slot && shadow_age[i] < hit_age)
						shadow_age[i]++;
				shadow_age[slot] = 0;
			end else if (op == KIND_INSERT) begin
				// full: push out the oldest valid entry and reuse its slot
				if (shadow_fill >= eff_cap) begin
					oldest = -1;
					for (int i = 0; i < LKC_ENTRIES; i++)
						if (shadow_valid[i] && (oldest < 0 || shadow_age[i] > shadow_age[oldest]))
							oldest = i;
					if (oldest >= 0) begin
						res.evicted_valid    = 1'b1;
						res.evicted_key      = shadow_key[oldest];
						shadow_valid[oldest] = 1'b0;
						shadow_fill--;
						slot = oldest;
					end
				end
				if (slot < 0)
					for (int i = 0; i < LKC_ENTRIES; i++)
						if (slot < 0 && !shadow_valid[i])
							slot = i;
				if (slot >= 0) begin
					for (int i = 0; i < LKC_ENTRIES; i++)
						if (shadow_valid[i])
							shadow_age[i]++;
					shadow_key[slot]   = k;
					shadow_valid[slot] = 1'b1;
					shadow_age[slot]   = 0;
					shadow_fill++;
				end
			end
		end
		return res;
	endfunction

	// result checker: every strobe is matched against the oldest expectation
	always @(posedge clk) begin
		lru_outcome_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no access pending");
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					mismatches++;
				end
				if (evicted_valid !== want.evicted_valid) begin
					$error("evicted_valid: expected %0d, got %0d",
						want.evicted_valid, evicted_valid);
					mismatches++;
				end
				if (evicted_key !== want.evicted_key) begin
					$error("evicted_key: expected %h, got %h", want.evicted_key, evicted_key);
					mismatches++;
				end
			end
		end
	end

	// drive one command beat and hold it until the block takes it
	// start is left high so a following beat can go out on the next edge
	task automatic send_beat(kind_t op, logic [FIELD_KEY_W-1:0] k);
		start <= 1'b1;
		kind  <= op;
		key   <= k;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(lru_access(op, k));
	endtask

	// random burst of idle cycles on the command side
	task automatic maybe_idle();
		int n;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 15);
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// wait for every result, then let the pipeline settle
	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// capacity write, only with the block idle; it also empties the store
	task automatic write_capacity(logic [CAP_W-1:0] v);
		start <= 1'b0;
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		shadow_cap  = v;
		shadow_clear();
	endtask

	// reset default of 16: miss on empty store, key extremes, hit on lookup and insert
	task automatic test_after_reset();
		send_beat(KIND_LOOKUP, 16'h0000);
		send_beat(KIND_INSERT, 16'h0000);
		send_beat(KIND_INSERT, 16'hFFFF);
		send_beat(KIND_LOOKUP, 16'hFFFF);
		send_beat(KIND_INSERT, 16'h0000);
	endtask

	// disabled cache: everything misses and nothing is stored
	task automatic test_capacity_zero();
		write_capacity(CAP_W'(0));
		send_beat(KIND_INSERT, 16'h1234);
		send_beat(KIND_LOOKUP, 16'h1234);
		send_beat(KIND_INSERT, 16'hFFFF);
	endtask

	// two entries: a lookup refreshes age, so the other key is the victim
	task automatic test_lru_order();
		write_capacity(CAP_W'(2));
		send_beat(KIND_INSERT, 16'h00A5);
		send_beat(KIND_INSERT, 16'h5A00);
		send_beat(KIND_LOOKUP, 16'h00A5);
		send_beat(KIND_INSERT, 16'h0F0F);
		send_beat(KIND_LOOKUP, 16'h5A00);
		send_beat(KIND_INSERT, 16'h5A00);
	endtask

	// one entry: every new key pushes out the previous one
	task automatic test_single_entry();
		write_capacity(CAP_W'(1));
		send_beat(KIND_INSERT, 16'h0001);
		send_beat(KIND_INSERT, 16'h8000);
	endtask

	// capacity above the entry count acts as a full-size cache
	task automatic test_capacity_saturate();
		write_capacity(CAP_W'(31));
		send_beat(KIND_INSERT, 16'hFFFF);
		send_beat(KIND_LOOKUP, 16'hFFFF);
	endtask

	// random traffic over a small key pool so hits and evictions are common,
	// with some fully random keys and key extremes mixed in
	task automatic test_random_traffic(logic [CAP_W-1:0] cap, int count, int pool_size,
		bit with_idle);
		logic [FIELD_KEY_W-1:0] pool [64];
		logic [FIELD_KEY_W-1:0] k;
		kind_t                  op;
		int                     r;
		write_capacity(cap);
		idle_on = with_idle;
		for (int i = 0; i < pool_size; i++)
			pool[i] = FIELD_KEY_W'($urandom_range(0, 65535));
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 19);
			if (r < 17)
				k = pool[$urandom_range(0, pool_size - 1)];
			else if (r < 19)
				k = FIELD_KEY_W'($urandom);
			else
				k = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			op = $urandom_range(0, 1) ? KIND_INSERT : KIND_LOOKUP;
			send_beat(op, k);
			maybe_idle();
		end
	endtask

	initial begin
		shadow_cap = CAP_RESET;
		shadow_clear();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_capacity_zero();
		test_lru_order();
		test_single_entry();
		test_capacity_saturate();

		// sweep of capacities, extremes included; the last phase runs flat out
		test_random_traffic(CAP_W'(16), 200, 24, 1'b1);
		test_random_traffic(CAP_W'(1),  120, 3,  1'b1);
		test_random_traffic(CAP_W'(31), 150, 22, 1'b1);
		test_random_traffic(CAP_W'(5),  150, 8,  1'b1);
		test_random_traffic(CAP_W'(0),  60,  4,  1'b1);
		test_random_traffic(CAP_W'(17), 150, 20, 1'b1);
		test_random_traffic(CAP_W'(8),  150, 12, 1'b1);
		test_random_traffic(CAP_W'(2),  120, 4,  1'b1);
		test_random_traffic(CAP_W'(16), 200, 40, 1'b1);
		test_random_traffic(CAP_W'(16), 150, 20, 1'b0);

		start <= 1'b0;
		wait_drained();
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
